// File: hw/rtl/cidrf_pkg.sv
// Shared types and constants for the chipset index/data register file.
// Holds the controller state type, command/status structs and port codes.
// Used by cidrf_ctrl, cidrf_dp and chipset_index_data_register_file.
package cidrf_pkg;

  localparam int REG_COUNT = 256;
  localparam int REG_AW    = $clog2(REG_COUNT);

  // Bus access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Port selectors.
  localparam logic [1:0] PORT_INDEX = 2'd0;
  localparam logic [1:0] PORT_DATA  = 2'd1;
  localparam logic [1:0] PORT_VIDEO = 2'd2;
  localparam logic [1:0] PORT_IO    = 2'd3;

  // Special indexes and bytes.
  localparam logic [REG_AW-1:0] IDX_LOCK          = REG_AW'(8'hff);
  localparam logic [REG_AW-1:0] IDX_CONFLICT      = REG_AW'(8'h20);
  localparam logic [REG_AW-1:0] IDX_CONFLICT_BASE = REG_AW'(8'hc0);
  localparam logic [REG_AW-1:0] IDX_E_SEG         = REG_AW'(8'h0a);
  localparam logic [REG_AW-1:0] IDX_F_SEG         = REG_AW'(8'h0b);
  localparam logic [7:0]        LOCK_BYTE         = 8'hff;
  localparam logic [7:0]        UNLOCK_FIRST      = 8'h14;
  localparam logic [7:0]        UNLOCK_SECOND     = 8'h09;
  localparam logic [7:0]        MASKED_BYTE       = 8'hff;

  // Configuration register addresses (byte address bits).
  localparam int               CFG_AW       = 3;
  localparam logic             CFG_IDX_CPU  = 1'b0;

  localparam int OUT_TDATA_W = 24;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } sts_t;

endpackage

// File: hw/rtl/cidrf_ctrl.sv
// Controller for the chipset register file: sequences accept and execute.
// Depends on cidrf_pkg for the state type and command/status structs.
module cidrf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  cidrf_pkg::sts_t sts,
  output cidrf_pkg::cmd_t cmd
);
  import cidrf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_EXEC: begin
        cmd.commit = sts.slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/cidrf_dp.sv
// Datapath of the chipset register file: the 256-byte file memory, the
// index/lock/control registers and the output register. Uses cidrf_pkg.
module cidrf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cidrf_pkg::cmd_t                     cmd,
  output cidrf_pkg::sts_t                     sts,
  input  logic                                cpu_mask,
  input  logic                                item_op,
  input  logic [1:0]                          item_port,
  input  logic [7:0]                          item_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cidrf_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import cidrf_pkg::*;

  // Latched item.
  logic            op_r;
  logic [1:0]      port_r;
  logic [7:0]      data_r;

  // Architectural state.
  logic [REG_AW-1:0] index_r,  index_nxt;
  logic [7:0]        last_r,   last_nxt;
  logic              locked_r, locked_nxt;
  logic [7:0]        video_r,  video_nxt;
  logic [7:0]        io_r,     io_nxt;
  logic [1:0]        emode_r,  emode_nxt;
  logic [1:0]        fmode_r,  fmode_nxt;

  // File memory with per-entry valid bits; an unwritten entry reads as zero.
  logic [7:0]           mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [7:0]           rd_data_r;
  logic                 rd_vld_r;
  logic                 mem_we;

  logic [7:0]                 read_byte;
  logic [7:0]                 file_byte;
  logic [OUT_TDATA_W-1:0]     out_tdata_r;
  logic                       out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= item_op;
      port_r <= item_port;
      data_r <= item_data;
    end
  end

  // The file is read every cycle at the current index; the data is used in
  // the execute cycle, which follows the cycle in which the item was taken.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[index_r] <= data_r;
    end
    rd_data_r <= mem[index_r];
    rd_vld_r  <= vld_r[index_r];
  end

  assign file_byte = rd_vld_r ? rd_data_r : 8'h00;

  always_comb begin
    index_nxt  = index_r;
    last_nxt   = last_r;
    locked_nxt = locked_r;
    video_nxt  = video_r;
    io_nxt     = io_r;
    emode_nxt  = emode_r;
    fmode_nxt  = fmode_r;
    mem_we     = 1'b0;
    read_byte  = 8'h00;
    if (op_r == OP_WRITE) begin
      case (port_r)
        PORT_INDEX: index_nxt = data_r;
        PORT_DATA: begin
          if (locked_r) begin
            if (last_r == UNLOCK_FIRST && data_r == UNLOCK_SECOND) locked_nxt = 1'b0;
            last_nxt = data_r;
          end else if (index_r == IDX_LOCK && data_r == LOCK_BYTE) begin
            locked_nxt = 1'b1;
          end else begin
            mem_we = cmd.commit;
            if (index_r == IDX_E_SEG) emode_nxt = data_r[5:4];
            if (index_r == IDX_F_SEG) fmode_nxt = data_r[5:4];
          end
        end
        PORT_VIDEO: video_nxt = data_r;
        default:    io_nxt    = data_r;
      endcase
    end else begin
      case (port_r)
        PORT_INDEX: read_byte = locked_r ? MASKED_BYTE : index_r;
        PORT_DATA: begin
          if (locked_r) begin
            read_byte = MASKED_BYTE;
          end else if (cpu_mask &&
                       (index_r >= IDX_CONFLICT_BASE || index_r == IDX_CONFLICT)) begin
            read_byte = MASKED_BYTE;
          end else begin
            read_byte = file_byte;
          end
        end
        PORT_VIDEO: read_byte = video_r;
        default:    read_byte = io_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r  <= '0;
      last_r   <= '0;
      locked_r <= 1'b0;
      video_r  <= '0;
      io_r     <= '0;
      emode_r  <= '0;
      fmode_r  <= '0;
      vld_r    <= '0;
    end else if (cmd.commit) begin
      index_r  <= index_nxt;
      last_r   <= last_nxt;
      locked_r <= locked_nxt;
      video_r  <= video_nxt;
      io_r     <= io_nxt;
      emode_r  <= emode_nxt;
      fmode_r  <= fmode_nxt;
      if (mem_we) vld_r[index_r] <= 1'b1;
    end
  end

  // Output register; it frees up in the same cycle its result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_tdata_r <= {7'b0, ~video_nxt[2], ~io_nxt[3], ~io_nxt[2], io_nxt[1:0],
                      fmode_nxt, emode_nxt, read_byte};
    end
  end

  assign sts.slot_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_tdata_r;

endmodule

// File: hw/rtl/chipset_index_data_register_file.sv
// Top level of the chipset index/data register file block.
// Instantiates cidrf_ctrl and cidrf_dp and holds the APB configuration
// register; depends on cidrf_pkg.
//
//   Channel   Direction  Handshake                  Contents
//   in_*      slave      in_tvalid / in_tready      one byte bus access
//   out_*     master     out_tvalid / out_tready    read byte and decoded controls
//   cfg_*     APB slave  psel, penable, pready      CPU select bit at byte address 0
//
// Each access is handled as the input transfer, then an execute cycle that
// uses the registered file read and updates the state; no new access is taken
// until the execute cycle is done. The execute cycle waits while the output
// register holds a result not yet taken; that result stays stable meanwhile.
// The synchronous reset clears one valid bit per file entry, so an entry that
// was never written reads as zero and no clearing pass is needed.
module chipset_index_data_register_file (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,  // [7:0] data
  input  logic [2:0]                          in_tuser,  // [0] op, [2:1] port
  // Output channel.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] read_data, [9:8] e_segment_mode, [11:10] f_segment_mode,
  // [13:12] parallel_select, [14] serial_one_enable, [15] serial_two_enable,
  // [16] video_enable, [23:17] zero
  output logic [cidrf_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Configuration port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [cidrf_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import cidrf_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cpu_mask_r;
  logic cfg_wr;

  // The register index is the word address; only index zero exists.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[CFG_AW-1] == CFG_IDX_CPU);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_mask_r <= 1'b0;
    end else if (cfg_wr) begin
      cpu_mask_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_AW-1] == CFG_IDX_CPU) cfg_prdata = {31'b0, cpu_mask_r};
  end

  cidrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cidrf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cpu_mask   (cpu_mask_r),
    .item_op    (in_tuser[0]),
    .item_port  (in_tuser[2:1]),
    .item_data  (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
